@@ src/alab_pkg.sv @@
// Package for the ambient light auto brightness block: segment table,
// status and register codes, and the fixed widths of the serial divider.
// No dependencies.
`default_nettype none

package alab_pkg;

    localparam int SEGMENTS    = 6;
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = 4;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 7;
    localparam int TIME_W   = 40;
    localparam int PAUSE_W  = 20;
    localparam int WEIGHT_W = 4;

    localparam int DVD_W = SAMPLE_W + LEVEL_W;
    localparam int DVS_W = SAMPLE_W;
    localparam int CNT_W = 5;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic [SAMPLE_W-1:0] upper;
        logic [LEVEL_W-1:0]  lo_level;
        logic [LEVEL_W-1:0]  hi_level;
    } seg_row_t;

    localparam seg_row_t SEG_TABLE [TABLE_SLOTS] = '{
        '{16'd5,      7'd5,  7'd20},
        '{16'd30,     7'd20, 7'd40},
        '{16'd100,    7'd40, 7'd60},
        '{16'd300,    7'd60, 7'd80},
        '{16'd800,    7'd80, 7'd95},
        '{16'hFFFF,   7'd95, 7'd100},
        '{16'd0, 7'd0, 7'd0}, '{16'd0, 7'd0, 7'd0},
        '{16'd0, 7'd0, 7'd0}, '{16'd0, 7'd0, 7'd0},
        '{16'd0, 7'd0, 7'd0}, '{16'd0, 7'd0, 7'd0},
        '{16'd0, 7'd0, 7'd0}, '{16'd0, 7'd0, 7'd0},
        '{16'd0, 7'd0, 7'd0}, '{16'd0, 7'd0, 7'd0}
    };

    localparam logic [2:0] STS_APPLIED  = 3'd0;
    localparam logic [2:0] STS_HELD     = 3'd1;
    localparam logic [2:0] STS_PAUSED   = 3'd2;
    localparam logic [2:0] STS_ABSENT   = 3'd3;
    localparam logic [2:0] STS_ERROR    = 3'd4;
    localparam logic [2:0] STS_OVERRIDE = 3'd5;

    localparam logic [1:0] RS_OK     = 2'd0;
    localparam logic [1:0] RS_ABSENT = 2'd1;

    localparam logic [1:0] REG_HYST   = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_PAUSE  = 2'd2;

    localparam logic [LEVEL_W-1:0]  HYST_RESET   = 7'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd1;
    localparam logic [PAUSE_W-1:0]  PAUSE_RESET  = 20'd30000;

endpackage

`default_nettype wire

@@ src/ambient_light_auto_brightness.sv @@
// Top level of the ambient light auto brightness block: stream ports,
// APB register port, control sequencer and bit-serial divider.
// Depends on alab_pkg.
`default_nettype none

// Each input beat is a poll or a manual override notice, and each gives
// exactly one result beat. Overrides, paused polls and failed reads go from
// acceptance straight to the result state, which loads the output register
// once it is free. A good poll first runs the control states and up to two
// passes of the restoring divider (segment interpolation, then smoothing).
// The divider retires one quotient bit a cycle. One item is worked on at a
// time; the next is accepted while the previous result still waits on the
// master side.
module ambient_light_auto_brightness (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // now_ms [39:0], light_sample [55:40], read_status [57:56], zeros
    input  wire logic [63:0]                 s_tdata,
    // mode [0]
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // level [6:0], drive_strobe [7]
    output logic [7:0]                       m_tdata,
    // status [2:0]
    output logic [2:0]                       m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [alab_pkg::ADDR_W-1:0] paddr,
    input  wire logic [alab_pkg::DATA_W-1:0] pwdata,
    output logic [alab_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import alab_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MAP    = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_POST   = 3'd4;
    localparam logic [2:0] ST_SMOOTH = 3'd5;
    localparam logic [2:0] ST_HYST   = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [LEVEL_W-1:0]  hyst_reg, hyst_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [PAUSE_W-1:0]  pause_reg, pause_next;
    logic [LEVEL_W-1:0]  smoothed_level_reg, smoothed_level_next;
    logic                smoothed_valid_reg, smoothed_valid_next;
    logic [LEVEL_W-1:0]  applied_level_reg, applied_level_next;
    logic                applied_valid_reg, applied_valid_next;
    logic [TIME_W-1:0]   pause_until_reg, pause_until_next;
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [2:0]          status_reg, status_next;
    logic                strobe_reg, strobe_next;
    logic [LEVEL_W-1:0]  target_reg, target_next;
    logic [LEVEL_W-1:0]  lo_level_reg, lo_level_next;
    logic [LEVEL_W-1:0]  hi_level_reg, hi_level_next;
    logic [LEVEL_W-1:0]  span_reg, span_next;
    logic [SAMPLE_W-1:0] offset_reg, offset_next;
    logic [DVS_W-1:0]    divisor_reg, divisor_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVD_W-1:0]    quo_reg, quo_next;
    logic [2:0]          m_status_reg, m_status_next;
    logic [LEVEL_W-1:0]  m_level_reg, m_level_next;
    logic                m_strobe_reg, m_strobe_next;

    logic                cfg_write;
    logic                s_accept;
    logic [TIME_W:0]     pause_sum;
    logic [TIME_W-1:0]   pause_end;
    logic                in_pause;
    logic [SLOT_W-1:0]   seg_idx;
    logic                seg_found;
    seg_row_t            seg_row;
    logic [SAMPLE_W-1:0] prev_upper;
    logic                map_direct;
    logic [DVS_W:0]      trial;
    logic                trial_ge;
    logic [DVS_W:0]      trial_diff;
    logic [DVD_W-1:0]    map_prod;
    logic [DVD_W:0]      map_val;
    logic [10:0]         smooth_prod;
    logic [10:0]         smooth_sum;
    logic [LEVEL_W-1:0]  level_diff;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_strobe_reg, m_level_reg};
    assign m_tuser   = m_status_reg;

    always_comb begin
        case (paddr[3:2])
            REG_HYST:   prdata = {{(DATA_W-LEVEL_W){1'b0}}, hyst_reg};
            REG_WEIGHT: prdata = {{(DATA_W-WEIGHT_W){1'b0}}, weight_reg};
            REG_PAUSE:  prdata = {{(DATA_W-PAUSE_W){1'b0}}, pause_reg};
            default:    prdata = '0;
        endcase
    end

    assign pause_sum = {1'b0, s_tdata[TIME_W-1:0]} + {{(TIME_W+1-PAUSE_W){1'b0}}, pause_reg};
    assign pause_end = pause_sum[TIME_W] ? {TIME_W{1'b1}} : pause_sum[TIME_W-1:0];
    assign in_pause  = (pause_until_reg != '0) && (s_tdata[TIME_W-1:0] < pause_until_reg);

    always_comb begin
        seg_idx   = '0;
        seg_found = 1'b0;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (!seg_found && (sample_reg <= SEG_TABLE[i].upper || i == SEGMENTS - 1)) begin
                seg_idx   = SLOT_W'(i);
                seg_found = 1'b1;
            end
        end
    end

    assign seg_row    = SEG_TABLE[seg_idx];
    assign prev_upper = (seg_idx == '0) ? '0 : SEG_TABLE[seg_idx - 1'b1].upper;
    assign map_direct = (seg_idx == '0) || (sample_reg <= prev_upper)
                        || (seg_row.upper <= prev_upper);

    assign trial      = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});
    assign trial_diff = trial - {1'b0, divisor_reg};

    assign map_prod    = DVD_W'(offset_reg) * DVD_W'(span_reg);
    assign map_val     = {{(DVD_W+1-LEVEL_W){1'b0}}, lo_level_reg} + {1'b0, quo_reg};
    assign smooth_prod = 11'(smoothed_level_reg) * 11'(weight_reg);
    assign smooth_sum  = smooth_prod + {4'd0, target_reg};
    assign level_diff  = (smoothed_level_reg >= applied_level_reg)
                         ? smoothed_level_reg - applied_level_reg
                         : applied_level_reg - smoothed_level_reg;

    always_comb begin
        state_next          = state_reg;
        hyst_next           = hyst_reg;
        weight_next         = weight_reg;
        pause_next          = pause_reg;
        smoothed_level_next = smoothed_level_reg;
        smoothed_valid_next = smoothed_valid_reg;
        applied_level_next  = applied_level_reg;
        applied_valid_next  = applied_valid_reg;
        pause_until_next    = pause_until_reg;
        phase_next          = phase_reg;
        cnt_next            = cnt_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        sample_next         = sample_reg;
        status_next         = status_reg;
        strobe_next         = strobe_reg;
        target_next         = target_reg;
        lo_level_next       = lo_level_reg;
        hi_level_next       = hi_level_reg;
        span_next           = span_reg;
        offset_next         = offset_reg;
        divisor_next        = divisor_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        m_status_next       = m_status_reg;
        m_level_next        = m_level_reg;
        m_strobe_next       = m_strobe_reg;

        if (cfg_write) begin
            case (paddr[3:2])
                REG_HYST:   hyst_next   = pwdata[LEVEL_W-1:0];
                REG_WEIGHT: weight_next = pwdata[WEIGHT_W-1:0];
                REG_PAUSE:  pause_next  = pwdata[PAUSE_W-1:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next = s_tdata[55:40];
                    strobe_next = 1'b0;
                    state_next  = ST_RESULT;
                    if (s_tuser) begin
                        pause_until_next = pause_end;
                        status_next      = STS_OVERRIDE;
                    end else if (in_pause) begin
                        status_next = STS_PAUSED;
                    end else begin
                        pause_until_next = '0;
                        if (s_tdata[57:56] == RS_OK) begin
                            state_next = ST_MAP;
                        end else if (s_tdata[57:56] == RS_ABSENT) begin
                            status_next = STS_ABSENT;
                        end else begin
                            status_next = STS_ERROR;
                        end
                    end
                end
            end
            ST_MAP: begin
                lo_level_next = seg_row.lo_level;
                hi_level_next = seg_row.hi_level;
                span_next     = (seg_row.hi_level >= seg_row.lo_level)
                                ? seg_row.hi_level - seg_row.lo_level : '0;
                offset_next   = sample_reg - prev_upper;
                divisor_next  = seg_row.upper - prev_upper;
                if (map_direct) begin
                    target_next = seg_row.lo_level;
                    state_next  = ST_SMOOTH;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                quo_next   = map_prod;
                rem_next   = '0;
                cnt_next   = '0;
                phase_next = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (!phase_reg) begin
                    target_next = (map_val > {{(DVD_W+1-LEVEL_W){1'b0}}, hi_level_reg})
                                  ? hi_level_reg : map_val[LEVEL_W-1:0];
                    state_next  = ST_SMOOTH;
                end else begin
                    smoothed_level_next = quo_reg[LEVEL_W-1:0];
                    state_next          = ST_HYST;
                end
            end
            ST_SMOOTH: begin
                if (!smoothed_valid_reg) begin
                    smoothed_level_next = target_reg;
                    smoothed_valid_next = 1'b1;
                    state_next          = ST_HYST;
                end else begin
                    quo_next     = {{(DVD_W-11){1'b0}}, smooth_sum};
                    divisor_next = {{(DVS_W-WEIGHT_W-1){1'b0}},
                                    {1'b0, weight_reg} + 1'b1};
                    rem_next     = '0;
                    cnt_next     = '0;
                    phase_next   = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_HYST: begin
                if (!applied_valid_reg || level_diff >= hyst_reg) begin
                    applied_level_next = smoothed_level_reg;
                    applied_valid_next = 1'b1;
                    status_next        = STS_APPLIED;
                    strobe_next        = 1'b1;
                end else begin
                    status_next = STS_HELD;
                    strobe_next = 1'b0;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // The result beat waits here until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_level_next  = smoothed_level_reg;
                    m_strobe_next = strobe_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            hyst_reg           <= HYST_RESET;
            weight_reg         <= WEIGHT_RESET;
            pause_reg          <= PAUSE_RESET;
            smoothed_level_reg <= '0;
            smoothed_valid_reg <= 1'b0;
            applied_level_reg  <= '0;
            applied_valid_reg  <= 1'b0;
            pause_until_reg    <= '0;
            phase_reg          <= 1'b0;
            cnt_reg            <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            hyst_reg           <= hyst_next;
            weight_reg         <= weight_next;
            pause_reg          <= pause_next;
            smoothed_level_reg <= smoothed_level_next;
            smoothed_valid_reg <= smoothed_valid_next;
            applied_level_reg  <= applied_level_next;
            applied_valid_reg  <= applied_valid_next;
            pause_until_reg    <= pause_until_next;
            phase_reg          <= phase_next;
            cnt_reg            <= cnt_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        status_reg   <= status_next;
        strobe_reg   <= strobe_next;
        target_reg   <= target_next;
        lo_level_reg <= lo_level_next;
        hi_level_reg <= hi_level_next;
        span_reg     <= span_next;
        offset_reg   <= offset_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        m_status_reg <= m_status_next;
        m_level_reg  <= m_level_next;
        m_strobe_reg <= m_strobe_next;
    end

endmodule

`default_nettype wire

@@ src/alab_checker.sv @@
// Port-level checker for the ambient light auto brightness block, and the
// bind statement that attaches it to the top level.
// Depends on alab_pkg and ambient_light_auto_brightness.
`default_nettype none

module alab_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser
);
    import alab_pkg::*;

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The drive strobe comes with an applied status and only with it.
    a_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == (m_tuser == STS_APPLIED)))
        else $error("drive strobe does not match status");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= STS_OVERRIDE)
        else $error("undefined status code");

    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] <= 7'd100)
        else $error("level above 100 percent");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ambient_light_auto_brightness alab_checker u_alab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
